@@ sv/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: request and status
// codes, the entry record and the control bundle broadcast to every cell.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DATA_W = 32;
   localparam int PRIO_W = 16;
   localparam int FILL_W = 5;
   localparam int STAT_W = 2;

   typedef enum logic {
      REQ_INSERT = 1'b0,
      REQ_REMOVE = 1'b1
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_INSERTED = 2'd0,
      ST_REMOVED  = 2'd1,
      ST_EMPTY    = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      logic signed [PRIO_W-1:0] prio;
   } entry_type;

   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type item;
   } cell_ctrl_type;

endpackage

@@ sv/spq_cell.sv @@
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row. On insert the slot keeps its entry when that
// entry sorts before or with the new one, takes the new entry at the boundary,
// and otherwise takes its left neighbor's entry. On remove it takes its right
// neighbor's entry.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   left_keep,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   output logic                   keep,
   output spq_pkg::entry_type     entry
);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;

   assign keep  = occupied && (entry_ff.prio <= ctrl.item.prio);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert) begin
         if (!keep) begin
            entry_in = left_keep ? ctrl.item : left_entry;
         end
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

@@ sv/sorted_priority_queue.sv @@
// ----------------------------------------------------------------------------
// sorted_priority_queue
// Bounded priority queue held as a row of compare-and-shift cells, smallest
// priority at the head, equal priorities in arrival order.
// ----------------------------------------------------------------------------
// Takes one request per clock cycle unless a held response stalls it. Every cell
// compares its priority with the incoming one in parallel and shifts in the same
// cycle, so the response shows up in the output register on the cycle after the
// request is accepted, and a new request is taken while that response is being
// taken. Throughput is set by the response register alone: one request per cycle
// while rsp_ready is high. Inserts into a full queue and removes from an empty
// one leave the queue unchanged and return their own status codes.
module sorted_priority_queue #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_item_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_item_priority,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic        [spq_pkg::STAT_W-1:0]   rsp_status,
   output logic signed [spq_pkg::DATA_W-1:0]   rsp_out_data,
   output logic signed [spq_pkg::PRIO_W-1:0]   rsp_out_priority,
   output logic        [spq_pkg::FILL_W-1:0]   rsp_fill_count
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic                   accept;
   logic                   is_remove;
   logic                   full;
   logic                   empty;
   spq_pkg::cell_ctrl_type ctrl;
   logic [QUEUE_DEPTH:0]   keep_chain;
   spq_pkg::entry_type     entries [QUEUE_DEPTH];

   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   spq_pkg::status_type    status_ff;
   spq_pkg::status_type    status_in;
   spq_pkg::entry_type     out_ff;
   spq_pkg::entry_type     out_in;
   logic [CW+spq_pkg::FILL_W-1:0] fill_ext;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_remove = (req_type == spq_pkg::REQ_REMOVE);
   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   assign ctrl.insert    = accept && !is_remove && !full;
   assign ctrl.remove    = accept && is_remove && !empty;
   assign ctrl.item.data = req_item_data;
   assign ctrl.item.prio = req_item_priority;

   assign keep_chain[0] = 1'b1;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_pkg::entry_type right_entry;
      spq_pkg::entry_type left_entry;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
      end else begin : g_mid
         assign right_entry = entries[i+1];
      end

      if (i == 0) begin : g_head
         assign left_entry = ctrl.item;
      end else begin : g_body
         assign left_entry = entries[i-1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > CW'(i)),
         .left_keep   (keep_chain[i]),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (keep_chain[i+1]),
         .entry       (entries[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CW'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_comb begin
      status_in = status_ff;
      out_in    = out_ff;
      if (accept) begin
         out_in = '0;
         priority if (!is_remove && full) begin
            status_in = spq_pkg::ST_FULL;
         end else if (!is_remove) begin
            status_in = spq_pkg::ST_INSERTED;
         end else if (empty) begin
            status_in = spq_pkg::ST_EMPTY;
         end else begin
            status_in = spq_pkg::ST_REMOVED;
            out_in    = entries[0];
         end
      end
   end

   assign rsp_valid_in = accept || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      out_ff    <= out_in;
   end

   assign fill_ext         = {{spq_pkg::FILL_W{1'b0}}, count_ff};
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_out_data     = out_ff.data;
   assign rsp_out_priority = out_ff.prio;
   assign rsp_fill_count   = fill_ext[spq_pkg::FILL_W-1:0];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   a_remove_empty: assert property (@(posedge clock) disable iff (reset)
      accept && is_remove && empty |=> rsp_status == spq_pkg::ST_EMPTY && count_ff == '0)
      else $error("remove on empty not reported");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      accept && !is_remove && !full |=> count_ff == $past(count_ff) + CW'(1))
      else $error("insert did not advance count");

   a_zero_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != spq_pkg::ST_REMOVED |-> out_ff == '0)
      else $error("payload not cleared on non-remove response");
`endif

endmodule

@@ dv/spq_checker.sv @@
// ----------------------------------------------------------------------------
// spq_checker
// Watches both handshake channels of the sorted priority queue. It keeps a
// shadow copy of the sorted list, works out the response for every accepted
// request and compares each accepted response, field by field, with the
// oldest outstanding prediction. It counts failures for the testbench top.
// ----------------------------------------------------------------------------
module spq_checker #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_type,
   input  logic signed [spq_pkg::DATA_W-1:0]   req_item_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]   req_item_priority,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic        [spq_pkg::STAT_W-1:0]   rsp_status,
   input  logic signed [spq_pkg::DATA_W-1:0]   rsp_out_data,
   input  logic signed [spq_pkg::PRIO_W-1:0]   rsp_out_priority,
   input  logic        [spq_pkg::FILL_W-1:0]   rsp_fill_count,
   output int                                  fail_count,
   output int                                  pending_count,
   output int                                  result_count,
   output int                                  full_count,
   output int                                  empty_count
);

   typedef struct {
      spq_pkg::status_type               status;
      logic signed [spq_pkg::DATA_W-1:0] data;
      logic signed [spq_pkg::PRIO_W-1:0] prio;
      logic        [spq_pkg::FILL_W-1:0] fill;
   } queue_result_type;

   spq_pkg::entry_type shadow_entry [QUEUE_DEPTH];
   int                 shadow_fill;
   queue_result_type   pending_results [$];

   function automatic queue_result_type predict_queue_op(
      input spq_pkg::req_kind_type kind,
      input spq_pkg::entry_type    item);
      queue_result_type res;
      int               pos;
      int               i;
      res.status = spq_pkg::ST_INSERTED;
      res.data   = '0;
      res.prio   = '0;
      if (kind == spq_pkg::REQ_INSERT) begin
         if (shadow_fill >= QUEUE_DEPTH) begin
            res.status = spq_pkg::ST_FULL;
         end else begin
            pos = 0;
            while (pos < shadow_fill &&
                   $signed(shadow_entry[pos].prio) <= $signed(item.prio)) begin
               pos++;
            end
            for (i = shadow_fill; i > pos; i--) begin
               shadow_entry[i] = shadow_entry[i-1];
            end
            shadow_entry[pos] = item;
            shadow_fill++;
         end
      end else if (shadow_fill == 0) begin
         res.status = spq_pkg::ST_EMPTY;
      end else begin
         res.status = spq_pkg::ST_REMOVED;
         res.data   = shadow_entry[0].data;
         res.prio   = shadow_entry[0].prio;
         for (i = 1; i < shadow_fill; i++) begin
            shadow_entry[i-1] = shadow_entry[i];
         end
         shadow_fill--;
      end
      res.fill = shadow_fill[spq_pkg::FILL_W-1:0];
      return res;
   endfunction

   always @(posedge clock) begin
      queue_result_type   want;
      spq_pkg::entry_type item;
      if (reset) begin
         shadow_fill = 0;
         pending_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            result_count++;
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               fail_count++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_status !== want.status) begin
                  $error("status mismatch: expected %0d, actual %0d",
                         want.status, rsp_status);
                  fail_count++;
               end
               if (rsp_out_data !== want.data) begin
                  $error("out_data mismatch: expected %0d, actual %0d",
                         want.data, rsp_out_data);
                  fail_count++;
               end
               if (rsp_out_priority !== want.prio) begin
                  $error("out_priority mismatch: expected %0d, actual %0d",
                         want.prio, rsp_out_priority);
                  fail_count++;
               end
               if (rsp_fill_count !== want.fill) begin
                  $error("fill_count mismatch: expected %0d, actual %0d",
                         want.fill, rsp_fill_count);
                  fail_count++;
               end
               if (want.status == spq_pkg::ST_FULL) full_count++;
               if (want.status == spq_pkg::ST_EMPTY) empty_count++;
            end
         end
         if (req_valid && req_ready) begin
            item.data = req_item_data;
            item.prio = req_item_priority;
            pending_results.push_back(
               predict_queue_op(spq_pkg::req_kind_type'(req_type), item));
         end
      end
      pending_count = pending_results.size();
   end

endmodule

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the sorted priority queue. Drives a directed run over the
// priority extremes, equal priorities, a full queue and an empty queue, then
// random insert/remove mixes under varying sender gaps and receiver stalls.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int QUEUE_DEPTH = 16;
   localparam int STALL_LIMIT = 2000;
   localparam int PHASE_ITEMS = 210;

   logic                              clock             = 1'b0;
   logic                              reset             = 1'b1;
   logic                              req_valid         = 1'b0;
   logic                              req_ready;
   logic                              req_type          = 1'b0;
   logic signed [spq_pkg::DATA_W-1:0] req_item_data     = '0;
   logic signed [spq_pkg::PRIO_W-1:0] req_item_priority = '0;
   logic                              rsp_valid;
   logic                              rsp_ready         = 1'b0;
   logic        [spq_pkg::STAT_W-1:0] rsp_status;
   logic signed [spq_pkg::DATA_W-1:0] rsp_out_data;
   logic signed [spq_pkg::PRIO_W-1:0] rsp_out_priority;
   logic        [spq_pkg::FILL_W-1:0] rsp_fill_count;

   int send_idle_pct = 30;
   int recv_idle_pct = 48;
   int fail_count;
   int pending_count;
   int result_count;
   int full_count;
   int empty_count;

   sorted_priority_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_fill_count    (rsp_fill_count)
   );

   spq_checker #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_item_data     (req_item_data),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_out_data      (rsp_out_data),
      .rsp_out_priority  (rsp_out_priority),
      .rsp_fill_count    (rsp_fill_count),
      .fail_count        (fail_count),
      .pending_count     (pending_count),
      .result_count      (result_count),
      .full_count        (full_count),
      .empty_count       (empty_count)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   function automatic logic signed [spq_pkg::PRIO_W-1:0] pick_priority();
      case ($urandom_range(3))
         0:       return spq_pkg::PRIO_W'($signed($urandom_range(8)) - 4);
         1:       return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         default: return spq_pkg::PRIO_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [spq_pkg::DATA_W-1:0] pick_data();
      case ($urandom_range(7))
         0:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         1:       return $urandom_range(1) ? 32'sh0 : -32'sd1;
         default: return spq_pkg::DATA_W'($urandom);
      endcase
   endfunction

   task automatic send_request(input spq_pkg::req_kind_type             kind,
                               input logic signed [spq_pkg::DATA_W-1:0] data,
                               input logic signed [spq_pkg::PRIO_W-1:0] prio);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid         <= 1'b0;
         req_type          <= 1'($urandom_range(1));
         req_item_data     <= spq_pkg::DATA_W'($urandom);
         req_item_priority <= spq_pkg::PRIO_W'($urandom);
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_type          <= kind;
      req_item_data     <= data;
      req_item_priority <= prio;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
   endtask

   task automatic run_random_phase(input int n_items);
      int insert_pct;
      int idx;
      insert_pct = 50;
      for (idx = 0; idx < n_items; idx++) begin
         if (idx % 40 == 0) begin
            case ($urandom_range(2))
               0:       insert_pct = 15;
               1:       insert_pct = 50;
               default: insert_pct = 85;
            endcase
         end
         if ($urandom_range(99) < insert_pct) begin
            send_request(spq_pkg::REQ_INSERT, pick_data(), pick_priority());
         end else begin
            send_request(spq_pkg::REQ_REMOVE, spq_pkg::DATA_W'($urandom),
                         spq_pkg::PRIO_W'($urandom));
         end
      end
   endtask

   initial begin : watchdog
      int stall_cycles;
      stall_cycles = 0;
      while (stall_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin : stimulus
      int idx;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      send_request(spq_pkg::REQ_REMOVE, spq_pkg::DATA_W'($urandom),
                   spq_pkg::PRIO_W'($urandom));
      send_request(spq_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 16'sh7FFF);
      send_request(spq_pkg::REQ_INSERT, 32'sh8000_0000, 16'sh8000);
      send_request(spq_pkg::REQ_INSERT, 32'sh0, 16'sh0);
      send_request(spq_pkg::REQ_INSERT, 32'sd1, 16'sd5);
      send_request(spq_pkg::REQ_INSERT, 32'sd2, 16'sd5);
      send_request(spq_pkg::REQ_INSERT, 32'sd3, 16'sd5);
      send_request(spq_pkg::REQ_INSERT, -32'sd1, -16'sd1);
      send_request(spq_pkg::REQ_INSERT, 32'sh5555_5555, 16'sh7FFF);
      send_request(spq_pkg::REQ_INSERT, 32'shAAAA_AAAA, 16'sh8000);
      for (idx = 0; idx < 7; idx++) begin
         send_request(spq_pkg::REQ_INSERT, spq_pkg::DATA_W'(idx + 100),
                      spq_pkg::PRIO_W'(idx * 3 - 7));
      end
      send_request(spq_pkg::REQ_INSERT, pick_data(), pick_priority());
      for (idx = 0; idx < 6; idx++) begin
         send_request(spq_pkg::REQ_REMOVE, spq_pkg::DATA_W'($urandom),
                      spq_pkg::PRIO_W'($urandom));
      end

      run_random_phase(PHASE_ITEMS);
      wait_for_drain();
      send_idle_pct = 48;
      recv_idle_pct = 30;
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random_phase(PHASE_ITEMS);
      wait_for_drain();
      repeat (8) @(negedge clock);

      $display("Checked %0d responses: directed corners, then random mixes under three",
               result_count);
      $display("gap/stall profiles; refused full inserts %0d, empty removes %0d.",
               full_count, empty_count);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
